>>> hdl/lspsq_pkg.sv
// ----------------------------------------------------------------------------
// Load/store page split queue package
// Item types, result codes and shared constants of the load/store queue.
// ----------------------------------------------------------------------------
package lspsq_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int unsigned BYTE_BITS  = 8;

  localparam logic [1:0] KIND_BUS_REQ   = 2'd0;
  localparam logic [1:0] KIND_CORE_RESP = 2'd1;
  localparam logic [1:0] KIND_REFUSED   = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  localparam logic REQ_CORE = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [31:0] addr;
    logic        is_store;
    logic [1:0]  size_code;
    logic [31:0] payload;
    logic [3:0]  byte_enable;
    logic        paging_on;
    logic        resp_ok;
  } lspsq_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] out_addr;
    logic        out_store;
    logic [1:0]  out_size;
    logic [31:0] out_data;
    logic [3:0]  out_strobe;
    logic        out_ok;
    logic        out_last;
  } lspsq_out_t;

  typedef struct packed {
    logic       store;
    logic       split;
    logic [2:0] num;
    logic [1:0] rcv;
  } lspsq_flags_t;

  typedef enum logic [1:0] {
    MODE_REFUSE,
    MODE_REQ,
    MODE_SPLIT,
    MODE_RESP
  } lspsq_mode_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic load_out;
  } lspsq_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       last_res;
    logic [2:0] num_res;
  } lspsq_sts_t;

endpackage

>>> hdl/lspsq_ctrl.sv
// ----------------------------------------------------------------------------
// Load/store page split queue controller
// Sequences capture, evaluation and result emission of one item at a time.
// ----------------------------------------------------------------------------
module lspsq_ctrl
  import lspsq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lspsq_sts_t sts_i,
  output lspsq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = (sts_i.num_res == 3'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.last_res) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/lspsq_dp.sv
// ----------------------------------------------------------------------------
// Load/store page split queue datapath
// Entry store, queue pointers, response assembly and the output register.
// ----------------------------------------------------------------------------
module lspsq_dp
  import lspsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lspsq_in_t  in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lspsq_out_t out_item_o,
  input  lspsq_cmd_t cmd_i,
  output lspsq_sts_t sts_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OffW = PAGE_SHIFT + 1;

  lspsq_flags_t flags_q [QUEUE_DEPTH];
  logic [31:0]  asm_q   [QUEUE_DEPTH];

  lspsq_in_t   item_q;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]  drop_q, drop_d;
  lspsq_mode_e mode_q, mode_d;
  logic [2:0]  nres_q, nres_d;
  logic [1:0]  k_q;
  logic [31:0] rdata_q, rdata_d;
  logic        rok_q, rok_d;
  logic        out_valid_q;
  lspsq_out_t  out_q, res;

  logic [1:0]   size_cl;
  logic [2:0]   nbytes;
  logic         split;
  lspsq_flags_t head_f, new_f;
  logic [2:0]   head_num;
  logic [2:0]   rcv_next;
  logic [31:0]  new_asm;
  logic         alloc, upd_head;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    idx_inc = (idx == IdxW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign size_cl  = (item_q.size_code == SIZE_RSVD) ? SIZE_WORD : item_q.size_code;
  assign nbytes   = 3'd1 << size_cl;
  assign split    = item_q.paging_on &&
                    (({1'b0, item_q.addr[PAGE_SHIFT-1:0]} + OffW'(nbytes)) >
                     OffW'(PAGE_BYTES));
  assign head_f   = flags_q[head_q];
  assign head_num = (head_f.num == 3'd0) ? 3'd1 : head_f.num;
  assign rcv_next = {1'b0, head_f.rcv} + 3'd1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    drop_d   = drop_q;
    mode_d   = mode_q;
    nres_d   = 3'd0;
    rdata_d  = rdata_q;
    rok_d    = rok_q;
    alloc    = 1'b0;
    upd_head = 1'b0;
    new_f    = head_f;
    new_asm  = asm_q[head_q];
    if (item_q.req_type == REQ_CORE) begin
      if (count_q == CntW'(QUEUE_DEPTH)) begin
        mode_d = MODE_REFUSE;
        nres_d = 3'd1;
      end else begin
        alloc   = 1'b1;
        new_f   = '{store: item_q.is_store, split: split,
                    num: split ? nbytes : 3'd1, rcv: 2'd0};
        new_asm = '0;
        tail_d  = idx_inc(tail_q);
        count_d = count_q + 1'b1;
        mode_d  = split ? MODE_SPLIT : MODE_REQ;
        nres_d  = split ? nbytes : 3'd1;
      end
    end else if (drop_q != 2'd0) begin
      drop_d = drop_q - 2'd1;
    end else if (count_q != '0) begin
      if (!item_q.resp_ok) begin
        drop_d  = (head_num > rcv_next) ? 2'(head_num - rcv_next) : 2'd0;
        head_d  = idx_inc(head_q);
        count_d = count_q - 1'b1;
        mode_d  = MODE_RESP;
        nres_d  = 3'd1;
        rdata_d = '0;
        rok_d   = 1'b0;
      end else begin
        upd_head = 1'b1;
        if (head_f.split) begin
          if (!head_f.store) begin
            new_asm = asm_q[head_q] |
                      (32'(item_q.payload[BYTE_BITS-1:0]) << {head_f.rcv, 3'b000});
          end
        end else begin
          new_asm = item_q.payload;
        end
        new_f.rcv = rcv_next[1:0];
        if (rcv_next >= head_num) begin
          head_d  = idx_inc(head_q);
          count_d = count_q - 1'b1;
          mode_d  = MODE_RESP;
          nres_d  = 3'd1;
          rdata_d = head_f.store ? '0 : new_asm;
          rok_d   = 1'b1;
        end
      end
    end
  end

  assign sts_o.num_res  = nres_d;
  assign sts_o.last_res = (({1'b0, k_q} + 3'd1) == nres_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    res = '0;
    case (mode_q)
      MODE_REFUSE: begin
        res.out_kind = KIND_REFUSED;
      end
      MODE_REQ: begin
        res.out_kind   = KIND_BUS_REQ;
        res.out_addr   = item_q.addr;
        res.out_store  = item_q.is_store;
        res.out_size   = size_cl;
        res.out_data   = item_q.payload;
        res.out_strobe = item_q.byte_enable;
      end
      MODE_SPLIT: begin
        res.out_kind   = KIND_BUS_REQ;
        res.out_addr   = item_q.addr + 32'(k_q);
        res.out_store  = item_q.is_store;
        res.out_size   = SIZE_BYTE;
        res.out_data   = 32'(item_q.payload[k_q*BYTE_BITS +: BYTE_BITS]);
        res.out_strobe = {3'b000, item_q.is_store & item_q.byte_enable[k_q]};
      end
      MODE_RESP: begin
        res.out_kind = KIND_CORE_RESP;
        res.out_data = rdata_q;
        res.out_ok   = rok_q;
      end
    endcase
    res.out_last = sts_o.last_res;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.eval) begin
      rdata_q <= rdata_d;
      rok_q   <= rok_d;
      if (alloc) begin
        flags_q[tail_q] <= new_f;
        asm_q[tail_q]   <= new_asm;
      end
      if (upd_head) begin
        flags_q[head_q] <= new_f;
        asm_q[head_q]   <= new_asm;
      end
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      drop_q      <= '0;
      mode_q      <= MODE_REFUSE;
      nres_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        drop_q  <= drop_d;
        mode_q  <= mode_d;
        nres_q  <= nres_d;
        k_q     <= '0;
      end else if (cmd_i.load_out) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hdl/load_store_page_split_queue_unit.sv
// ----------------------------------------------------------------------------
// Load/store page split queue unit
// In-order queue of core load/store requests with page-crossing byte split.
// ----------------------------------------------------------------------------
// One input channel carries core requests and bus responses alike; req_type
// tells them apart. One output channel carries bus requests, core responses
// and refusals; out_last marks the final result caused by an input item.
// An item is taken when in_valid_i is high and in_stall_o low, a result
// when out_valid_o is high and out_stall_i low.
// One item is worked on at a time: it is captured, the queue is updated,
// then its results are loaded into the single output register one by one
// (none, one, or two or four byte requests for a page-crossing access),
// as the controller sequence and the output register allow. The next
// item is taken once the last result is loaded into the output register,
// even while that result still waits.
// A stalled receiver holds the output register and the emission sequence.
// Reset empties the queue, clears the pointers and drops any pending result.
// ----------------------------------------------------------------------------
module load_store_page_split_queue_unit
  import lspsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lspsq_in_t  in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lspsq_out_t out_item_o
);

  lspsq_cmd_t cmd;
  lspsq_sts_t sts;

  lspsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lspsq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
